@@ sv/etmq_pkg.sv @@
package etmq_pkg;

  localparam int ENTITY_SLOTS    = 64;
  localparam int COMPONENT_TYPES = 32;

  // fixed field widths
  localparam int CMD_W  = 3;
  localparam int ID_W   = 6;
  localparam int CID_W  = 5;
  localparam int QM_W   = 32;
  localparam int RECL_W = 7;
  localparam int STAT_W = 2;

  // widths that follow the table size, and a compare width one bit wider than an id
  localparam int IDX_W = $clog2(ENTITY_SLOTS);
  localparam int CNT_W = $clog2(ENTITY_SLOTS + 1);
  localparam int CMP_W = ID_W + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE   = 3'd0,
    CMD_ADD      = 3'd1,
    CMD_REMOVE   = 3'd2,
    CMD_CONTAINS = 3'd3,
    CMD_DESTROY  = 3'd4,
    CMD_SWEEP    = 3'd5,
    CMD_QUERY    = 3'd6,
    CMD_RESERVED = 3'd7
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_ALLOC = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CREATE,
    S_POP,
    S_ENT,
    S_RMW,
    S_SCAN_RD,
    S_SCAN_EV,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [ID_W-1:0]  entity_id;
    logic [CID_W-1:0] component_id;
    logic [QM_W-1:0]  query_mask;
    logic             want_alive;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0]   result_id;
    logic              bit_value;
    logic [RECL_W-1:0] reclaimed;
    logic [STAT_W-1:0] status;
    logic              last;
  } out_t;

  typedef struct packed {
    logic                       exists;
    logic                       alive;
    logic [COMPONENT_TYPES-1:0] mask;
  } entry_t;

  // verdicts of the shared entry unit
  typedef struct packed {
    logic has_bit;
    logic match;
    logic reclaim;
  } alu_flags_t;

endpackage

@@ sv/etmq_entry_mem.sv @@
module etmq_entry_mem (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [etmq_pkg::IDX_W-1:0]    rd_addr_i,
  output etmq_pkg::entry_t              rd_data_o,
  input  logic                          wr_en_i,
  input  logic [etmq_pkg::IDX_W-1:0]    wr_addr_i,
  input  etmq_pkg::entry_t              wr_data_i
);

  etmq_pkg::entry_t                      mem [etmq_pkg::ENTITY_SLOTS];
  logic [etmq_pkg::ENTITY_SLOTS-1:0]     valid_q;
  etmq_pkg::entry_t                      rd_q;
  logic                                  rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // never-written entries read as the cleared entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_q : '0;

endmodule

@@ sv/etmq_id_stack.sv @@
module etmq_id_stack (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [etmq_pkg::ID_W-1:0]    push_id_i,
  input  logic                         pop_i,
  output logic [etmq_pkg::ID_W-1:0]    pop_id_o,
  output logic [etmq_pkg::CNT_W-1:0]   depth_o
);

  logic [etmq_pkg::ID_W-1:0]  mem [etmq_pkg::ENTITY_SLOTS];
  logic [etmq_pkg::CNT_W-1:0] depth_q, depth_d;
  logic [etmq_pkg::CNT_W-1:0] top_idx;
  logic                       do_push;
  logic [etmq_pkg::ID_W-1:0]  pop_q;

  assign top_idx = depth_q - etmq_pkg::CNT_W'(1);
  assign do_push = push_i && (depth_q < etmq_pkg::CNT_W'(etmq_pkg::ENTITY_SLOTS));

  always_comb begin
    depth_d = depth_q;
    if (do_push) begin
      depth_d = depth_q + etmq_pkg::CNT_W'(1);
    end else if (pop_i) begin
      depth_d = top_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[depth_q[etmq_pkg::IDX_W-1:0]] <= push_id_i;
    end
    if (pop_i) begin
      pop_q <= mem[top_idx[etmq_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else begin
      depth_q <= depth_d;
    end
  end

  assign pop_id_o = pop_q;
  assign depth_o  = depth_q;

endmodule

@@ sv/etmq_alu.sv @@
module etmq_alu (
  input  logic [etmq_pkg::CMD_W-1:0] cmd_i,
  input  etmq_pkg::entry_t           entry_i,
  input  logic [etmq_pkg::CID_W-1:0] cid_i,
  input  logic [etmq_pkg::QM_W-1:0]  qmask_i,
  input  logic                       want_i,
  output etmq_pkg::entry_t           entry_o,
  output etmq_pkg::alu_flags_t       flags_o
);

  logic                                  comp_ok;
  logic [etmq_pkg::QM_W-1:0]             bit_wide;
  logic [etmq_pkg::COMPONENT_TYPES-1:0]  bit_sel;
  logic [etmq_pkg::QM_W-1:0]             mask_wide;

  assign comp_ok   = {1'b0, cid_i} < (etmq_pkg::CID_W + 1)'(etmq_pkg::COMPONENT_TYPES);
  assign bit_wide  = comp_ok ? (etmq_pkg::QM_W'(1) << cid_i) : '0;
  assign bit_sel   = etmq_pkg::COMPONENT_TYPES'(bit_wide);
  assign mask_wide = etmq_pkg::QM_W'(entry_i.mask);

  always_comb begin
    entry_o         = entry_i;
    flags_o.has_bit = |(entry_i.mask & bit_sel);
    // query bits beyond the stored mask never match
    flags_o.match   = ((mask_wide & qmask_i) == qmask_i) && (entry_i.alive == want_i);
    flags_o.reclaim = entry_i.exists && !entry_i.alive;
    case (cmd_i)
      etmq_pkg::CMD_ADD:     entry_o.mask  = entry_i.mask | bit_sel;
      etmq_pkg::CMD_REMOVE:  entry_o.mask  = entry_i.mask & ~bit_sel;
      etmq_pkg::CMD_DESTROY: entry_o.alive = 1'b0;
      etmq_pkg::CMD_SWEEP:   entry_o       = '0;
      default:               entry_o       = entry_i;
    endcase
  end

endmodule

@@ sv/entity_table_mask_query_engine.sv @@
// Entity table engine: one command per input transaction, one result transaction per
// command except query, which gives one per matching id (last marks the final one; no
// match gives a single empty result) and command code 7, which gives none. The table
// sits in one entry memory with a registered read port and is updated by one shared
// entry unit under a small sequencer; sweep and query walk every id handed out so far,
// and results wait while the output side stalls. Per-entry valid flops clear the
// table at reset, so the block is ready right after reset.
module entity_table_mask_query_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  etmq_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output etmq_pkg::out_t  out_data_o
);

  etmq_pkg::state_e             state_q, state_d;
  etmq_pkg::in_t                in_q, in_d;
  logic [etmq_pkg::CNT_W-1:0]   hw_q, hw_d;
  logic [etmq_pkg::CNT_W-1:0]   idx_q, idx_d;
  logic [etmq_pkg::CNT_W-1:0]   count_q, count_d;
  logic                         pend_valid_q, pend_valid_d;
  logic [etmq_pkg::IDX_W-1:0]   pend_id_q, pend_id_d;
  logic                         out_valid_q, out_valid_d;
  etmq_pkg::out_t               out_q, out_d;

  logic                         out_free;
  logic                         accept;
  logic                         emit;
  etmq_pkg::out_t               res;

  logic                         mem_rd_en;
  logic [etmq_pkg::IDX_W-1:0]   mem_rd_addr;
  etmq_pkg::entry_t             mem_rd_data;
  logic                         mem_wr_en;
  logic [etmq_pkg::IDX_W-1:0]   mem_wr_addr;
  etmq_pkg::entry_t             mem_wr_data;
  etmq_pkg::entry_t             fresh;

  logic                         push;
  logic                         pop;
  logic [etmq_pkg::ID_W-1:0]    pop_id;
  logic [etmq_pkg::CNT_W-1:0]   depth;

  etmq_pkg::entry_t             alu_entry;
  etmq_pkg::alu_flags_t         alu_flags;

  logic                         not_alloc;
  logic                         has_fresh;
  logic                         scan_end;
  logic                         is_entity_op;
  logic                         is_scan_op;

  assign out_free  = !out_valid_q || out_ready_i;
  assign accept    = in_valid_i && in_ready_o;
  assign not_alloc = etmq_pkg::CMP_W'(in_q.entity_id) >= etmq_pkg::CMP_W'(hw_q);
  assign has_fresh = hw_q < etmq_pkg::CNT_W'(etmq_pkg::ENTITY_SLOTS);
  assign scan_end  = idx_q >= hw_q;
  assign is_entity_op = in_data_i.command inside {etmq_pkg::CMD_ADD, etmq_pkg::CMD_REMOVE,
                                                  etmq_pkg::CMD_CONTAINS,
                                                  etmq_pkg::CMD_DESTROY};
  assign is_scan_op   = in_data_i.command inside {etmq_pkg::CMD_SWEEP, etmq_pkg::CMD_QUERY};

  always_comb begin
    fresh        = '0;
    fresh.exists = 1'b1;
    fresh.alive  = 1'b1;
  end

  etmq_entry_mem u_entry_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data)
  );

  etmq_id_stack u_id_stack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_id_i (etmq_pkg::ID_W'(idx_q)),
    .pop_i     (pop),
    .pop_id_o  (pop_id),
    .depth_o   (depth)
  );

  etmq_alu u_alu (
    .cmd_i   (in_q.command),
    .entry_i (mem_rd_data),
    .cid_i   (in_q.component_id),
    .qmask_i (in_q.query_mask),
    .want_i  (in_q.want_alive),
    .entry_o (alu_entry),
    .flags_o (alu_flags)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      etmq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.command == etmq_pkg::CMD_CREATE) begin
            state_d = etmq_pkg::S_CREATE;
          end else if (is_entity_op) begin
            state_d = etmq_pkg::S_ENT;
          end else if (is_scan_op) begin
            state_d = etmq_pkg::S_SCAN_RD;
          end
        end
      end
      etmq_pkg::S_CREATE: begin
        if (out_free) begin
          state_d = (depth != '0) ? etmq_pkg::S_POP : etmq_pkg::S_IDLE;
        end
      end
      etmq_pkg::S_POP: state_d = etmq_pkg::S_IDLE;
      etmq_pkg::S_ENT: begin
        if (!not_alloc) begin
          state_d = etmq_pkg::S_RMW;
        end else if (out_free) begin
          state_d = etmq_pkg::S_IDLE;
        end
      end
      etmq_pkg::S_RMW: begin
        if (out_free) begin
          state_d = etmq_pkg::S_IDLE;
        end
      end
      etmq_pkg::S_SCAN_RD: begin
        state_d = scan_end ? etmq_pkg::S_DONE : etmq_pkg::S_SCAN_EV;
      end
      etmq_pkg::S_SCAN_EV: begin
        // a second match needs room to push out the one held back
        if ((in_q.command != etmq_pkg::CMD_QUERY) || !alu_flags.match
            || !pend_valid_q || out_free) begin
          state_d = etmq_pkg::S_SCAN_RD;
        end
      end
      etmq_pkg::S_DONE: begin
        if (out_free) begin
          state_d = etmq_pkg::S_IDLE;
        end
      end
      default: state_d = etmq_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    in_ready_o   = (state_q == etmq_pkg::S_IDLE);
    in_d         = accept ? in_data_i : in_q;
    hw_d         = hw_q;
    idx_d        = idx_q;
    count_d      = count_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    emit         = 1'b0;
    res          = '0;
    res.status   = etmq_pkg::ST_OK;
    res.last     = 1'b1;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = in_q.entity_id[etmq_pkg::IDX_W-1:0];
    mem_wr_en    = 1'b0;
    mem_wr_addr  = idx_q[etmq_pkg::IDX_W-1:0];
    mem_wr_data  = alu_entry;
    push         = 1'b0;
    pop          = 1'b0;
    case (state_q)
      etmq_pkg::S_IDLE: begin
        if (accept) begin
          idx_d        = '0;
          count_d      = '0;
          pend_valid_d = 1'b0;
        end
      end
      etmq_pkg::S_CREATE: begin
        if (out_free) begin
          if (depth != '0) begin
            pop = 1'b1;
          end else if (has_fresh) begin
            mem_wr_en     = 1'b1;
            mem_wr_addr   = hw_q[etmq_pkg::IDX_W-1:0];
            mem_wr_data   = fresh;
            hw_d          = hw_q + etmq_pkg::CNT_W'(1);
            emit          = 1'b1;
            res.result_id = etmq_pkg::ID_W'(hw_q);
          end else begin
            emit       = 1'b1;
            res.status = etmq_pkg::ST_FULL;
          end
        end
      end
      etmq_pkg::S_POP: begin
        // output stayed free since the create state checked it
        mem_wr_en     = 1'b1;
        mem_wr_addr   = pop_id[etmq_pkg::IDX_W-1:0];
        mem_wr_data   = fresh;
        emit          = 1'b1;
        res.result_id = pop_id;
      end
      etmq_pkg::S_ENT: begin
        if (!not_alloc) begin
          mem_rd_en = 1'b1;
        end else if (out_free) begin
          emit       = 1'b1;
          res.status = etmq_pkg::ST_NOT_ALLOC;
        end
      end
      etmq_pkg::S_RMW: begin
        if (out_free) begin
          mem_wr_en     = (in_q.command != etmq_pkg::CMD_CONTAINS);
          mem_wr_addr   = in_q.entity_id[etmq_pkg::IDX_W-1:0];
          emit          = 1'b1;
          res.bit_value = (in_q.command == etmq_pkg::CMD_CONTAINS) && alu_flags.has_bit;
        end
      end
      etmq_pkg::S_SCAN_RD: begin
        if (!scan_end) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = idx_q[etmq_pkg::IDX_W-1:0];
        end
      end
      etmq_pkg::S_SCAN_EV: begin
        if (in_q.command == etmq_pkg::CMD_QUERY) begin
          if (!alu_flags.match) begin
            idx_d = idx_q + etmq_pkg::CNT_W'(1);
          end else if (!pend_valid_q || out_free) begin
            emit          = pend_valid_q;
            res.result_id = etmq_pkg::ID_W'(pend_id_q);
            res.bit_value = 1'b1;
            res.last      = 1'b0;
            pend_valid_d  = 1'b1;
            pend_id_d     = idx_q[etmq_pkg::IDX_W-1:0];
            idx_d         = idx_q + etmq_pkg::CNT_W'(1);
          end
        end else begin
          if (alu_flags.reclaim) begin
            mem_wr_en = 1'b1;
            push      = 1'b1;
            count_d   = count_q + etmq_pkg::CNT_W'(1);
          end
          idx_d = idx_q + etmq_pkg::CNT_W'(1);
        end
      end
      etmq_pkg::S_DONE: begin
        if (out_free) begin
          emit = 1'b1;
          if (in_q.command == etmq_pkg::CMD_QUERY) begin
            res.result_id = pend_valid_q ? etmq_pkg::ID_W'(pend_id_q) : '0;
            res.bit_value = pend_valid_q;
            pend_valid_d  = 1'b0;
          end else begin
            res.reclaimed = etmq_pkg::RECL_W'(count_q);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_d       = emit ? res : out_q;
    out_valid_d = emit || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= etmq_pkg::S_IDLE;
      hw_q         <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      hw_q         <= hw_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q      <= in_d;
    idx_q     <= idx_d;
    count_q   <= count_d;
    pend_id_q <= pend_id_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
